>>> hdl/i2p_pkg.sv
// Shared types and token codes for the infix-to-postfix converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2p_pkg;

    localparam logic [2:0] KIND_NUM   = 3'd0;
    localparam logic [2:0] KIND_OP    = 3'd1;
    localparam logic [2:0] KIND_OPEN  = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_VAR   = 3'd4;
    localparam logic [2:0] KIND_FUNC  = 3'd5;

    localparam int unsigned VALUE_W = 32;

    // One stacked token: 37 bits.
    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] value;
        logic [1:0]         prec;
    } entry_t;

    // One result before the run_last and expression_done marks are known.
    typedef struct packed {
        entry_t tok;
        logic   err;
    } result_t;

    localparam result_t ERROR_RESULT = '{tok: '0, err: 1'b1};

endpackage

`default_nettype wire

>>> hdl/i2p_stack.sv
// Operator stack storage: single write port, one registered read port.
// Depends on i2p_pkg for the entry type.
`default_nettype none

module i2p_stack
    import i2p_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-during-write at the same address returns the old entry.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix (shunting-yard) converter.
// Depends on i2p_pkg and instantiates the operator stack i2p_stack.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | input     | in_valid/in_stall  | token_kind, token_value, token_precedence,
//           |           |                    | last_token
//   out     | output    | out_valid/out_stall| out_kind, out_value, out_precedence,
//           |           |                    | error_flag, run_last, expression_done
//
// One token at a time: in_stall stays high from the accept edge until its work is done.
// Each token goes from dispatch to S_OPPOP if it is an operator, to S_CLPOP and S_CLFUNC if it is a
// close parenthesis, popping one entry per step there, then to S_END, to S_FLUSH for a last token,
// and to S_FINISH. A skipped token goes from dispatch back to idle, or to S_FINISH if last.
// One result is held back for run_last; a stalled output halts the sequencer on each beat.
// Reset (rst_n, asynchronous) empties the stack; the memory itself needs no clearing.
`default_nettype none

module infix_to_postfix_converter
    import i2p_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         token_kind,
    input  wire logic [VALUE_W-1:0] token_value,
    input  wire logic [1:0]         token_precedence,
    input  wire logic               last_token,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              out_kind,
    output logic [VALUE_W-1:0]      out_value,
    output logic [1:0]              out_precedence,
    output logic                    error_flag,
    output logic                    run_last,
    output logic                    expression_done
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_OPPOP    = 3'd2;
    localparam logic [2:0] S_CLPOP    = 3'd3;
    localparam logic [2:0] S_CLFUNC   = 3'd4;
    localparam logic [2:0] S_END      = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          skip_reg, skip_next;

    entry_t        tok_reg, tok_next;
    logic          last_reg, last_next;

    result_t       pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;

    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_run_last_reg, out_run_last_next;
    logic          out_done_reg, out_done_next;

    logic          wr_en;
    entry_t        top;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] rd_addr;

    logic          out_free;
    logic          emit_ok;
    logic          emit_req;
    result_t       emit_data;
    logic          finish_req;
    logic          stack_full;
    logic          pop_op;

    // The read address follows the next count, so the registered top is
    // current in the cycle after any pop; after a push, S_END lets the write land.
    assign count_m1 = count_next - CW'(1);
    assign rd_addr  = (count_next == '0) ? '0 : count_m1[AW-1:0];

    i2p_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (tok_reg),
        .rd_addr (rd_addr),
        .rd_data (top)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign stack_full = (count_reg == DEPTH_C);
    assign pop_op   = (count_reg != '0) && (top.kind != KIND_OPEN)
                      && (top.prec >= tok_reg.prec);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        emit_req   = 1'b0;
        emit_data  = ERROR_RESULT;
        finish_req = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tok_next   = '{kind: token_kind, value: token_value,
                                   prec: token_precedence};
                    last_next  = last_token;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (emit_ok)
                begin
                    if (skip_reg)
                    begin
                        if (last_reg)
                        begin
                            emit_req   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        unique case (tok_reg.kind)
                            KIND_NUM, KIND_VAR:
                            begin
                                emit_req   = 1'b1;
                                emit_data  = '{tok: tok_reg, err: 1'b0};
                                state_next = S_END;
                            end
                            KIND_OPEN, KIND_FUNC:
                            begin
                                if (stack_full)
                                begin
                                    emit_req   = 1'b1;
                                    count_next = '0;
                                    skip_next  = !last_reg;
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                    state_next = S_END;
                                end
                            end
                            KIND_OP:    state_next = S_OPPOP;
                            KIND_CLOSE: state_next = S_CLPOP;
                            default:    state_next = S_END;
                        endcase
                    end
                end
            end
            S_OPPOP:
            begin
                if (emit_ok)
                begin
                    priority if (pop_op)
                    begin
                        emit_req   = 1'b1;
                        emit_data  = '{tok: top, err: 1'b0};
                        count_next = count_reg - CW'(1);
                    end
                    else if (stack_full)
                    begin
                        emit_req   = 1'b1;
                        count_next = '0;
                        skip_next  = !last_reg;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        state_next = S_END;
                    end
                end
            end
            S_CLPOP:
            begin
                if (emit_ok)
                begin
                    priority if (count_reg == '0)
                    begin
                        emit_req   = 1'b1;
                        skip_next  = !last_reg;
                        state_next = S_FINISH;
                    end
                    else if (top.kind != KIND_OPEN)
                    begin
                        emit_req   = 1'b1;
                        emit_data  = '{tok: top, err: 1'b0};
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        // Drop the matching open parenthesis.
                        count_next = count_reg - CW'(1);
                        state_next = S_CLFUNC;
                    end
                end
            end
            S_CLFUNC:
            begin
                if (emit_ok)
                begin
                    if ((count_reg != '0) && (top.kind == KIND_FUNC))
                    begin
                        emit_req   = 1'b1;
                        emit_data  = '{tok: top, err: 1'b0};
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_END;
                end
            end
            S_END:
            begin
                state_next = last_reg ? S_FLUSH : S_FINISH;
            end
            S_FLUSH:
            begin
                if (emit_ok)
                begin
                    priority if (count_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (top.kind == KIND_OPEN)
                    begin
                        // An open parenthesis was never closed.
                        emit_req   = 1'b1;
                        count_next = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        emit_req   = 1'b1;
                        emit_data  = '{tok: top, err: 1'b0};
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    finish_req = 1'b1;
                    if (last_reg)
                    begin
                        count_next = '0;
                        skip_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result holding stage and output register.
    always_comb
    begin
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_run_last_next = out_run_last_reg;
        out_done_next     = out_done_reg;

        if (emit_req)
        begin
            if (pend_valid_reg)
            begin
                out_next          = pend_reg;
                out_valid_next    = 1'b1;
                out_run_last_next = 1'b0;
                out_done_next     = 1'b0;
            end
            pend_next       = emit_data;
            pend_valid_next = 1'b1;
        end
        else if (finish_req)
        begin
            if (pend_valid_reg || last_reg)
            begin
                // With nothing held, a last token still reports an end marker.
                out_next          = pend_valid_reg ? pend_reg : result_t'('0);
                out_valid_next    = 1'b1;
                out_run_last_next = 1'b1;
                out_done_next     = last_reg;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            skip_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            skip_reg       <= skip_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg          <= tok_next;
        last_reg         <= last_next;
        pend_reg         <= pend_next;
        out_reg          <= out_next;
        out_run_last_reg <= out_run_last_next;
        out_done_reg     <= out_done_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_reg.tok.kind;
    assign out_value       = out_reg.tok.value;
    assign out_precedence  = out_reg.tok.prec;
    assign error_flag      = out_reg.err;
    assign run_last        = out_run_last_reg;
    assign expression_done = out_done_reg;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C
    ) else $error("stack count exceeds depth");

    a_idle_nothing_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg
    ) else $error("result still held while idle");

    a_last_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free && last_reg)
            |=> (count_reg == '0 && !skip_reg)
    ) else $error("stack not empty after the last token");

    a_done_is_run_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && expression_done) |-> run_last
    ) else $error("expression end without run end");

    a_error_payload_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && error_flag)
            |-> (out_kind == '0 && out_value == '0 && out_precedence == '0)
    ) else $error("error beat carries a token");
`endif

endmodule

`default_nettype wire
